[hdl/mti_pkg.sv]
// ============================================================================
// mti_pkg
// Shared widths, constants and the sideband type for the intercept solver.
// ============================================================================
package mti_pkg;

   // Fraction bits of the intercept time.
   localparam int TIME_FRAC = 16;
   localparam int TIME_W    = 32;

   // Discriminant and its integer square root.
   localparam int ROOT_W = 60;
   localparam int DISC_W = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 2;

   // Coefficient widths.
   localparam int A_W    = 50;   // signed |v|^2 - s^2
   localparam int ABSA_W = 49;
   localparam int B_W    = 59;   // signed 2 v.d
   localparam int DEN_W  = 58;   // |b| or 2|a|
   localparam int C_W    = 66;   // |d|^2
   localparam int NUM_W  = 66;

   // Data that travels beside the discriminant through the square root.
   typedef struct packed {
      logic signed [B_W-1:0] b;
      logic [DEN_W-1:0]      den;
      logic [C_W-1:0]        c;
      logic                  a_zero;
      logic                  a_neg;
      logic                  pre_ok;
      logic [2:0][31:0]      pos;
      logic [2:0][23:0]      vel;
   } mti_side_type;

endpackage

[hdl/moving_target_intercept_top.sv]
// ============================================================================
// moving_target_intercept_top
// Intercept solver for a constant-velocity target: time and aim point.
// ============================================================================
// The block takes one query per cycle and returns one result per query, in
// order. The fixed pipeline is eight stages that build the quadratic
// coefficients and the discriminant, sixty stages of the bit-per-stage
// square root, one stage for root selection, one for the time overflow
// test, thirty-two stages of the bit-per-stage divider, and two stages for
// the aim point. The whole pipeline holds while a result waits at the
// output and is not taken; otherwise a query enters in every cycle.
// Time is unsigned Q16.16; when no positive time exists, every result field
// but the valid flag is zero.
module moving_target_intercept_top
   import mti_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_shooter_x,
   input  logic signed [31:0] req_shooter_y,
   input  logic signed [31:0] req_shooter_z,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [31:0] req_target_z,
   input  logic signed [23:0] req_target_vel_x,
   input  logic signed [23:0] req_target_vel_y,
   input  logic signed [23:0] req_target_vel_z,
   input  logic        [23:0] req_projectile_speed,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_hit_valid,
   output logic        [31:0] rsp_intercept_time,
   output logic signed [31:0] rsp_aim_x,
   output logic signed [31:0] rsp_aim_y,
   output logic signed [31:0] rsp_aim_z,
   output logic               rsp_saturated
);

   localparam int DIV_N = TIME_W;
   localparam int SIDE_W = $bits(mti_side_type);

   logic en;
   logic out_v_ff;

   // All stages move together unless a result is stuck at the output.
   assign en        = !out_v_ff || rsp_ready;
   assign req_ready = en;

   // ---------------------------------------------------------------- S1
   logic signed [31:0] in_pos [3];
   logic signed [31:0] in_sht [3];
   logic signed [23:0] in_vel [3];

   always_comb begin
      in_pos[0] = req_target_x;
      in_pos[1] = req_target_y;
      in_pos[2] = req_target_z;
      in_sht[0] = req_shooter_x;
      in_sht[1] = req_shooter_y;
      in_sht[2] = req_shooter_z;
      in_vel[0] = req_target_vel_x;
      in_vel[1] = req_target_vel_y;
      in_vel[2] = req_target_vel_z;
   end

   logic               s1_v_ff;
   logic signed [32:0] s1_d_ff   [3];
   logic signed [31:0] s1_pos_ff [3];
   logic signed [23:0] s1_vel_ff [3];
   logic        [23:0] s1_spd_ff;

   // Relative position of the target.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_valid;
      end
      if (en) begin
         for (int ax = 0; ax < 3; ax++) begin
            s1_d_ff[ax]   <= 33'(in_pos[ax]) - 33'(in_sht[ax]);
            s1_pos_ff[ax] <= in_pos[ax];
            s1_vel_ff[ax] <= in_vel[ax];
         end
         s1_spd_ff <= req_projectile_speed;
      end
   end

   // ---------------------------------------------------------------- S2
   logic               s2_v_ff;
   logic signed [47:0] s2_vv_ff  [3];
   logic signed [56:0] s2_vd_ff  [3];
   logic        [64:0] s2_dd_ff  [3];
   logic        [47:0] s2_ss_ff;
   logic signed [31:0] s2_pos_ff [3];
   logic signed [23:0] s2_vel_ff [3];
   logic signed [65:0] dd_full   [3];

   always_comb begin
      for (int ax = 0; ax < 3; ax++) begin
         dd_full[ax] = 66'(s1_d_ff[ax]) * 66'(s1_d_ff[ax]);
      end
   end

   // Per-axis products for the three coefficients.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (en) begin
         s2_v_ff <= s1_v_ff;
      end
      if (en) begin
         for (int ax = 0; ax < 3; ax++) begin
            s2_vv_ff[ax]  <= 48'(s1_vel_ff[ax]) * 48'(s1_vel_ff[ax]);
            s2_vd_ff[ax]  <= 57'(s1_vel_ff[ax]) * 57'(s1_d_ff[ax]);
            s2_dd_ff[ax]  <= dd_full[ax][64:0];
            s2_pos_ff[ax] <= s1_pos_ff[ax];
            s2_vel_ff[ax] <= s1_vel_ff[ax];
         end
         s2_ss_ff <= 48'(s1_spd_ff) * 48'(s1_spd_ff);
      end
   end

   // ---------------------------------------------------------------- S3
   logic                  s3_v_ff;
   logic signed [A_W-1:0] s3_a_ff;
   logic signed [B_W-1:0] s3_b_ff;
   logic [C_W-1:0]        s3_c_ff;
   logic signed [31:0]    s3_pos_ff [3];
   logic signed [23:0]    s3_vel_ff [3];
   logic signed [57:0]    vd_sum;

   assign vd_sum = 58'(s2_vd_ff[0]) + 58'(s2_vd_ff[1]) + 58'(s2_vd_ff[2]);

   // Coefficients a, b and c.
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s3_v_ff <= s2_v_ff;
      end
      if (en) begin
         s3_a_ff <= A_W'(s2_vv_ff[0]) + A_W'(s2_vv_ff[1]) + A_W'(s2_vv_ff[2])
                    - $signed({2'b00, s2_ss_ff});
         s3_b_ff <= {vd_sum, 1'b0};
         s3_c_ff <= C_W'(s2_dd_ff[0]) + C_W'(s2_dd_ff[1]) + C_W'(s2_dd_ff[2]);
         for (int ax = 0; ax < 3; ax++) begin
            s3_pos_ff[ax] <= s2_pos_ff[ax];
            s3_vel_ff[ax] <= s2_vel_ff[ax];
         end
      end
   end

   // ---------------------------------------------------------------- S4
   logic                  s4_v_ff;
   logic [ABSA_W-1:0]     s4_abs_a_ff;
   logic [DEN_W-1:0]      s4_abs_b_ff;
   mti_side_type          s4_side_ff;
   mti_side_type          side_s4_in;
   logic signed [A_W-1:0] neg_a;
   logic signed [B_W-1:0] neg_b;
   logic [ABSA_W-1:0]     abs_a;
   logic [DEN_W-1:0]      abs_b;

   // Magnitudes, case flags and the divisor of either case.
   always_comb begin
      neg_a = -s3_a_ff;
      neg_b = -s3_b_ff;
      abs_a = s3_a_ff[A_W-1] ? neg_a[ABSA_W-1:0] : s3_a_ff[ABSA_W-1:0];
      abs_b = s3_b_ff[B_W-1] ? neg_b[DEN_W-1:0] : s3_b_ff[DEN_W-1:0];
      side_s4_in.b      = s3_b_ff;
      side_s4_in.c      = s3_c_ff;
      side_s4_in.a_zero = (s3_a_ff == '0);
      side_s4_in.a_neg  = s3_a_ff[A_W-1];
      // The linear case needs b below zero and a nonzero c.
      side_s4_in.pre_ok = s3_b_ff[B_W-1] && (s3_c_ff != '0);
      side_s4_in.den    = (s3_a_ff == '0) ? abs_b : DEN_W'({abs_a, 1'b0});
      for (int ax = 0; ax < 3; ax++) begin
         side_s4_in.pos[ax] = s3_pos_ff[ax];
         side_s4_in.vel[ax] = s3_vel_ff[ax];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (en) begin
         s4_v_ff <= s3_v_ff;
      end
      if (en) begin
         s4_abs_a_ff <= abs_a;
         s4_abs_b_ff <= abs_b;
         s4_side_ff  <= side_s4_in;
      end
   end

   // ---------------------------------------------------------------- S5
   logic         s5_v_ff;
   logic [57:0]  s5_bll_ff;
   logic [57:0]  s5_blh_ff;
   logic [57:0]  s5_bhh_ff;
   logic [46:0]  s5_pl_ff [3];
   logic [46:0]  s5_ph_ff [3];
   mti_side_type s5_side_ff;

   // Partial products of b squared and of c times |a|.
   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
      end else if (en) begin
         s5_v_ff <= s4_v_ff;
      end
      if (en) begin
         s5_bll_ff <= 58'(s4_abs_b_ff[28:0]) * 58'(s4_abs_b_ff[28:0]);
         s5_blh_ff <= 58'(s4_abs_b_ff[28:0]) * 58'(s4_abs_b_ff[57:29]);
         s5_bhh_ff <= 58'(s4_abs_b_ff[57:29]) * 58'(s4_abs_b_ff[57:29]);
         for (int k = 0; k < 3; k++) begin
            s5_pl_ff[k] <= 47'(s4_side_ff.c[22*k +: 22]) * 47'(s4_abs_a_ff[24:0]);
            s5_ph_ff[k] <= 47'(s4_side_ff.c[22*k +: 22]) * 47'(s4_abs_a_ff[48:25]);
         end
         s5_side_ff <= s4_side_ff;
      end
   end

   // ---------------------------------------------------------------- S6
   logic         s6_v_ff;
   logic [115:0] s6_b2_ff;
   logic [70:0]  s6_ca_ff [3];
   mti_side_type s6_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_v_ff <= 1'b0;
      end else if (en) begin
         s6_v_ff <= s5_v_ff;
      end
      if (en) begin
         s6_b2_ff <= (116'(s5_bhh_ff) << 58) + (116'(s5_blh_ff) << 30)
                     + 116'(s5_bll_ff);
         for (int k = 0; k < 3; k++) begin
            s6_ca_ff[k] <= 71'(s5_pl_ff[k]) + (71'(s5_ph_ff[k]) << 25);
         end
         s6_side_ff <= s5_side_ff;
      end
   end

   // ---------------------------------------------------------------- S7
   logic         s7_v_ff;
   logic [115:0] s7_b2_ff;
   logic [116:0] s7_fac_ff;
   mti_side_type s7_side_ff;

   // Four a c.
   always_ff @(posedge clock) begin
      if (reset) begin
         s7_v_ff <= 1'b0;
      end else if (en) begin
         s7_v_ff <= s6_v_ff;
      end
      if (en) begin
         s7_b2_ff   <= s6_b2_ff;
         s7_fac_ff  <= (117'(s6_ca_ff[0]) + (117'(s6_ca_ff[1]) << 22)
                       + (117'(s6_ca_ff[2]) << 44)) << 2;
         s7_side_ff <= s6_side_ff;
      end
   end

   // ---------------------------------------------------------------- S8
   logic              s8_v_ff;
   logic [DISC_W-1:0] s8_disc_ff;
   mti_side_type      s8_side_ff;
   mti_side_type      side_s8_in;
   logic              a_pos;
   logic              real_roots;

   // Discriminant; a positive a with b squared below 4ac has no real root.
   always_comb begin
      a_pos      = !s7_side_ff.a_neg && !s7_side_ff.a_zero;
      real_roots = !(a_pos && (117'(s7_b2_ff) < s7_fac_ff));
      side_s8_in = s7_side_ff;
      side_s8_in.pre_ok = s7_side_ff.a_zero ? s7_side_ff.pre_ok : real_roots;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_v_ff <= 1'b0;
      end else if (en) begin
         s8_v_ff <= s7_v_ff;
      end
      if (en) begin
         s8_disc_ff <= a_pos ? DISC_W'(s7_b2_ff) - DISC_W'(s7_fac_ff)
                             : DISC_W'(s7_b2_ff) + DISC_W'(s7_fac_ff);
         s8_side_ff <= side_s8_in;
      end
   end

   // ---------------------------------------------------------------- square root
   logic              sq_v;
   logic [ROOT_W-1:0] sq_root;
   logic [SIDE_W-1:0] sq_side_raw;
   mti_side_type      sq_side;

   mti_isqrt #(
      .SIDE_W (SIDE_W)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s8_v_ff),
      .in_disc   (s8_disc_ff),
      .in_side   (s8_side_ff),
      .out_valid (sq_v),
      .out_root  (sq_root),
      .out_side  (sq_side_raw)
   );

   assign sq_side = mti_side_type'(sq_side_raw);

   // ---------------------------------------------------------------- S9
   logic               s9_v_ff;
   logic               s9_hit_ff;
   logic [NUM_W-1:0]   s9_num_ff;
   logic [DEN_W-1:0]   s9_den_ff;
   logic [2:0][31:0]   s9_pos_ff;
   logic [2:0][23:0]   s9_vel_ff;
   logic signed [61:0] bx;
   logic signed [61:0] sq;
   logic signed [61:0] lo_n;
   logic signed [61:0] hi_n;
   logic signed [61:0] n_sel;

   // Smaller root, or the larger one when the smaller is negative.
   always_comb begin
      bx = 62'(sq_side.b);
      sq = $signed({2'b00, sq_root});
      if (sq_side.a_neg) begin
         lo_n = bx - sq;
         hi_n = bx + sq;
      end else begin
         lo_n = -bx - sq;
         hi_n = -bx + sq;
      end
      n_sel = lo_n[61] ? hi_n : lo_n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_v_ff <= 1'b0;
      end else if (en) begin
         s9_v_ff <= sq_v;
      end
      if (en) begin
         s9_hit_ff <= sq_side.pre_ok && (sq_side.a_zero || (n_sel > 62'sd0));
         s9_num_ff <= sq_side.a_zero ? sq_side.c : NUM_W'(n_sel);
         s9_den_ff <= sq_side.den;
         s9_pos_ff <= sq_side.pos;
         s9_vel_ff <= sq_side.vel;
      end
   end

   // ---------------------------------------------------------------- divider
   logic              dv_v_ff   [0:DIV_N];
   logic              dv_hit_ff [0:DIV_N];
   logic              dv_sat_ff [0:DIV_N];
   logic [DEN_W-1:0]  dv_rem_ff [0:DIV_N];
   logic [DEN_W-1:0]  dv_den_ff [0:DIV_N];
   logic [TIME_FRAC-1:0] dv_low_ff [0:DIV_N];
   logic [TIME_W-1:0] dv_q_ff   [0:DIV_N];
   logic [2:0][31:0]  dv_pos_ff [0:DIV_N];
   logic [2:0][23:0]  dv_vel_ff [0:DIV_N];

   // A quotient of 2^32 or more saturates the time.
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (en) begin
         dv_v_ff[0] <= s9_v_ff;
      end
      if (en) begin
         dv_hit_ff[0] <= s9_hit_ff;
         dv_sat_ff[0] <= (74'(s9_num_ff) >= {s9_den_ff, 16'h0000});
         dv_rem_ff[0] <= DEN_W'(s9_num_ff[NUM_W-1:TIME_FRAC]);
         dv_den_ff[0] <= s9_den_ff;
         dv_low_ff[0] <= s9_num_ff[TIME_FRAC-1:0];
         dv_q_ff[0]   <= '0;
         dv_pos_ff[0] <= s9_pos_ff;
         dv_vel_ff[0] <= s9_vel_ff;
      end
   end

   // One quotient bit per stage.
   for (genvar k = 0; k < DIV_N; k++) begin : g_div
      logic [DEN_W:0]   rem_t;
      logic             take;

      always_comb begin
         rem_t = {dv_rem_ff[k], dv_low_ff[k][TIME_FRAC-1]};
         take  = (rem_t >= {1'b0, dv_den_ff[k]});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[k+1] <= 1'b0;
         end else if (en) begin
            dv_v_ff[k+1] <= dv_v_ff[k];
         end
         if (en) begin
            dv_rem_ff[k+1] <= take ? DEN_W'(rem_t - {1'b0, dv_den_ff[k]})
                                   : rem_t[DEN_W-1:0];
            dv_q_ff[k+1]   <= {dv_q_ff[k][TIME_W-2:0], take};
            dv_low_ff[k+1] <= {dv_low_ff[k][TIME_FRAC-2:0], 1'b0};
            dv_hit_ff[k+1] <= dv_hit_ff[k];
            dv_sat_ff[k+1] <= dv_sat_ff[k];
            dv_den_ff[k+1] <= dv_den_ff[k];
            dv_pos_ff[k+1] <= dv_pos_ff[k];
            dv_vel_ff[k+1] <= dv_vel_ff[k];
         end
      end
   end

   // ---------------------------------------------------------------- A1
   logic               a1_v_ff;
   logic               a1_hit_ff;
   logic               a1_tsat_ff;
   logic [TIME_W-1:0]  a1_t_ff;
   logic signed [56:0] a1_prod_ff [3];
   logic [2:0][31:0]   a1_pos_ff;
   logic [TIME_W-1:0]  t_clamp;

   assign t_clamp = dv_sat_ff[DIV_N] ? '1 : dv_q_ff[DIV_N];

   // Distance traveled by the target in the clamped time.
   always_ff @(posedge clock) begin
      if (reset) begin
         a1_v_ff <= 1'b0;
      end else if (en) begin
         a1_v_ff <= dv_v_ff[DIV_N];
      end
      if (en) begin
         a1_hit_ff  <= dv_hit_ff[DIV_N];
         a1_tsat_ff <= dv_sat_ff[DIV_N];
         a1_t_ff    <= t_clamp;
         a1_pos_ff  <= dv_pos_ff[DIV_N];
         for (int ax = 0; ax < 3; ax++) begin
            a1_prod_ff[ax] <= 57'($signed(dv_vel_ff[DIV_N][ax]))
                              * $signed({25'd0, t_clamp});
         end
      end
   end

   // ---------------------------------------------------------------- output
   logic signed [40:0] delta   [3];
   logic signed [41:0] aim_sum [3];
   logic signed [31:0] aim_cl  [3];
   logic [2:0]         aim_sat;

   // Target plus the floored travel, clamped to 32 bits.
   always_comb begin
      for (int ax = 0; ax < 3; ax++) begin
         delta[ax]   = a1_prod_ff[ax][56:16];
         aim_sum[ax] = 42'($signed(a1_pos_ff[ax])) + 42'(delta[ax]);
         aim_sat[ax] = 1'b1;
         if (aim_sum[ax] > 42'sh0_7FFF_FFFF) begin
            aim_cl[ax] = 32'sh7FFF_FFFF;
         end else if (aim_sum[ax] < -42'sh0_8000_0000) begin
            aim_cl[ax] = 32'sh8000_0000;
         end else begin
            aim_cl[ax]  = aim_sum[ax][31:0];
            aim_sat[ax] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= a1_v_ff;
      end
      if (en) begin
         rsp_hit_valid      <= a1_hit_ff;
         rsp_intercept_time <= a1_hit_ff ? a1_t_ff : '0;
         rsp_aim_x          <= a1_hit_ff ? aim_cl[0] : '0;
         rsp_aim_y          <= a1_hit_ff ? aim_cl[1] : '0;
         rsp_aim_z          <= a1_hit_ff ? aim_cl[2] : '0;
         rsp_saturated      <= a1_hit_ff && (a1_tsat_ff || (aim_sat != '0));
      end
   end

   assign rsp_valid = out_v_ff;

endmodule

[hdl/mti_isqrt.sv]
// ============================================================================
// mti_isqrt
// Pipelined integer floor square root, one result bit per stage, with a
// sideband that travels beside each item.
// ============================================================================
module mti_isqrt
   import mti_pkg::*;
#(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [DISC_W-1:0] in_disc,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output logic [SIDE_W-1:0] out_side
);

   logic              v_ff    [1:ROOT_W];
   logic [REM_W-1:0]  rem_ff  [1:ROOT_W];
   logic [ROOT_W-1:0] root_ff [1:ROOT_W];
   logic [DISC_W-1:0] disc_ff [1:ROOT_W];
   logic [SIDE_W-1:0] side_ff [1:ROOT_W];

   // Each stage brings down two discriminant bits and decides one root bit.
   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic              v_cur;
      logic [REM_W-1:0]  rem_cur;
      logic [ROOT_W-1:0] root_cur;
      logic [DISC_W-1:0] disc_cur;
      logic [SIDE_W-1:0] side_cur;
      logic [REM_W+1:0] rem_t;
      logic [REM_W+1:0] trial;
      logic [REM_W-1:0] rem_in;
      logic [ROOT_W-1:0] root_in;

      // The first stage works on the incoming item itself.
      if (k == 0) begin : g_head
         assign v_cur    = in_valid;
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign disc_cur = in_disc;
         assign side_cur = in_side;
      end else begin : g_body
         assign v_cur    = v_ff[k];
         assign rem_cur  = rem_ff[k];
         assign root_cur = root_ff[k];
         assign disc_cur = disc_ff[k];
         assign side_cur = side_ff[k];
      end

      always_comb begin
         rem_t = {rem_cur, disc_cur[DISC_W-1 -: 2]};
         trial = {2'b00, root_cur, 2'b01};
         if (rem_t >= trial) begin
            rem_in  = REM_W'(rem_t - trial);
            root_in = {root_cur[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_t[REM_W-1:0];
            root_in = {root_cur[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (en) begin
            v_ff[k+1] <= v_cur;
         end
         if (en) begin
            rem_ff[k+1]  <= rem_in;
            root_ff[k+1] <= root_in;
            disc_ff[k+1] <= {disc_cur[DISC_W-3:0], 2'b00};
            side_ff[k+1] <= side_cur;
         end
      end
   end

   assign out_valid = v_ff[ROOT_W];
   assign out_root  = root_ff[ROOT_W];
   assign out_side  = side_ff[ROOT_W];

endmodule
